// File: rtl/lmsa_pkg.sv
// ----------------------------------------------------------------------------
// lmsa_pkg
// Shared types and constants for the spiral animator of a multiplexed LED
// matrix: register map, register widths and reset values, walker phases.
// ----------------------------------------------------------------------------
package lmsa_pkg;

    // Configuration register map.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_STEP = 1'd1;

    // Register widths and reset values.
    localparam int DWELL_BASE_W = 8;
    localparam int DWELL_STEP_W = 6;

    localparam logic [DWELL_BASE_W-1:0] DWELL_BASE_RESET = 8'd10;
    localparam logic [DWELL_STEP_W-1:0] DWELL_STEP_RESET = 6'd3;

    localparam int DWELL_BASE_MAX = (2 ** DWELL_BASE_W) - 1;
    localparam int DWELL_STEP_MAX = (2 ** DWELL_STEP_W) - 1;

    // Output field widths.
    localparam int OUT_W      = 8;
    localparam int RING_OUT_W = 2;

    // Edge of the current ring that the walker is on, in clockwise order.
    typedef enum logic [1:0] {
        PHASE_TOP    = 2'd0,
        PHASE_RIGHT  = 2'd1,
        PHASE_BOTTOM = 2'd2,
        PHASE_LEFT   = 2'd3
    } phase_t;

endpackage

// File: rtl/lmsa_walker.sv
// ----------------------------------------------------------------------------
// lmsa_walker
// Spiral walker and dwell counter. Requests one pixel inversion at the start
// of each dwell and steps clockwise through the rings when a dwell runs out.
// ----------------------------------------------------------------------------
module lmsa_walker
    import lmsa_pkg::*;
#(
    parameter int MATRIX_SIDE = 8
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 tick_en,
    input  logic [DWELL_BASE_W-1:0]              dwell_base,
    input  logic [DWELL_STEP_W-1:0]              dwell_step,
    output logic                                 toggle_en,
    output logic [$clog2(MATRIX_SIDE)-1:0]       toggle_row,
    output logic [$clog2(MATRIX_SIDE)-1:0]       toggle_col,
    output logic [((MATRIX_SIDE/2 > 1) ? $clog2(MATRIX_SIDE/2) : 1)-1:0] ring
);

    localparam int RC_W    = $clog2(MATRIX_SIDE);
    localparam int RINGS   = MATRIX_SIDE / 2;
    localparam int RING_W  = (RINGS > 1) ? $clog2(RINGS) : 1;
    localparam int LEN_W   = $clog2(MATRIX_SIDE + 1);
    localparam int DWELL_W =
        $clog2((DWELL_BASE_MAX + DWELL_STEP_MAX * (RINGS - 1)) * MATRIX_SIDE + 1);

    logic [RING_W-1:0]  ring_reg,  ring_next;
    phase_t             phase_reg, phase_next;
    logic [RC_W-1:0]    pos_reg,   pos_next;
    logic [DWELL_W-1:0] dwell_reg, dwell_next;

    logic [DWELL_BASE_W-1:0] base_eff;
    logic [DWELL_W-1:0]      dwell_load;
    logic [DWELL_W-1:0]      dwell_cur;
    logic [RC_W-1:0]         lo;
    logic [RC_W-1:0]         hi;
    logic [LEN_W-1:0]        ring_len;
    logic [LEN_W-1:0]        edge_len;
    logic [LEN_W-1:0]        pos_inc;

    // A toggle is due on a tick when the dwell count has run down to zero.
    assign toggle_en = tick_en && (dwell_reg == '0);
    assign ring      = ring_reg;

    // Dwell length for the current ring; a zero base counts as one.
    always_comb
    begin
        base_eff   = (dwell_base == '0) ? DWELL_BASE_W'(1) : dwell_base;
        dwell_load = (DWELL_W'(base_eff) + DWELL_W'(dwell_step) * DWELL_W'(ring_reg))
                     * DWELL_W'(MATRIX_SIDE);
        dwell_cur  = (dwell_reg == '0) ? dwell_load : dwell_reg;
    end

    // Pixel under the walker.
    always_comb
    begin
        lo = RC_W'(ring_reg);
        hi = RC_W'(MATRIX_SIDE - 1) - lo;
        case (phase_reg)
            PHASE_TOP:
            begin
                toggle_row = lo;
                toggle_col = lo + pos_reg;
            end
            PHASE_RIGHT:
            begin
                toggle_row = lo + RC_W'(1) + pos_reg;
                toggle_col = hi;
            end
            PHASE_BOTTOM:
            begin
                toggle_row = hi;
                toggle_col = hi - RC_W'(1) - pos_reg;
            end
            default:
            begin
                toggle_row = hi - RC_W'(1) - pos_reg;
                toggle_col = lo;
            end
        endcase
    end

    // Next walker position. The left edge of a two-wide ring is empty and is
    // skipped straight to the top edge of the next ring.
    always_comb
    begin
        ring_len = LEN_W'(MATRIX_SIDE) - (LEN_W'(ring_reg) << 1);
        case (phase_reg)
            PHASE_TOP:  edge_len = ring_len;
            PHASE_LEFT: edge_len = ring_len - LEN_W'(2);
            default:    edge_len = ring_len - LEN_W'(1);
        endcase
        pos_inc = LEN_W'(pos_reg) + LEN_W'(1);

        ring_next  = ring_reg;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        dwell_next = dwell_reg;

        if (tick_en)
        begin
            dwell_next = dwell_cur - DWELL_W'(1);
            if (dwell_next == '0)
            begin
                if (pos_inc < edge_len)
                begin
                    pos_next = RC_W'(pos_inc);
                end
                else
                begin
                    pos_next = '0;
                    if ((phase_reg == PHASE_LEFT) ||
                        ((phase_reg == PHASE_BOTTOM) && (ring_len == LEN_W'(2))))
                    begin
                        phase_next = PHASE_TOP;
                        ring_next  = (ring_reg == RING_W'(RINGS - 1)) ?
                                     '0 : ring_reg + RING_W'(1);
                    end
                    else if (phase_reg == PHASE_TOP)
                    begin
                        phase_next = PHASE_RIGHT;
                    end
                    else if (phase_reg == PHASE_RIGHT)
                    begin
                        phase_next = PHASE_BOTTOM;
                    end
                    else
                    begin
                        phase_next = PHASE_LEFT;
                    end
                end
            end
        end
    end

    // Walker and dwell registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg  <= '0;
            phase_reg <= PHASE_TOP;
            pos_reg   <= '0;
            dwell_reg <= '0;
        end
        else
        begin
            ring_reg  <= ring_next;
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            dwell_reg <= dwell_next;
        end
    end

endmodule

// File: rtl/lmsa_frame.sv
// ----------------------------------------------------------------------------
// lmsa_frame
// One-bit frame store, one row vector per matrix row. Applies the walker's
// pixel inversion and reads out the rows of the column being scanned.
// ----------------------------------------------------------------------------
module lmsa_frame
    import lmsa_pkg::*;
#(
    parameter int MATRIX_SIDE = 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           toggle_en,
    input  logic [$clog2(MATRIX_SIDE)-1:0] toggle_row,
    input  logic [$clog2(MATRIX_SIDE)-1:0] toggle_col,
    input  logic [$clog2(MATRIX_SIDE)-1:0] scan_col,
    output logic [MATRIX_SIDE-1:0]         col_rows
);

    localparam int RC_W = $clog2(MATRIX_SIDE);

    logic [MATRIX_SIDE-1:0] frame_reg  [MATRIX_SIDE];
    logic [MATRIX_SIDE-1:0] frame_next [MATRIX_SIDE];
    logic [MATRIX_SIDE-1:0] col_mask;

    // Apply the inversion to its row; the column readout sees the new value.
    always_comb
    begin
        col_mask = '0;
        col_mask[toggle_col] = 1'b1;
        for (int j = 0; j < MATRIX_SIDE; j++)
        begin
            frame_next[j] = frame_reg[j];
            if (toggle_en && (toggle_row == RC_W'(j)))
            begin
                frame_next[j] = frame_reg[j] ^ col_mask;
            end
            col_rows[j] = frame_next[j][scan_col];
        end
    end

    // Frame storage; reset lights every pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MATRIX_SIDE; j++)
            begin
                frame_reg[j] <= '1;
            end
        end
        else
        begin
            for (int j = 0; j < MATRIX_SIDE; j++)
            begin
                frame_reg[j] <= frame_next[j];
            end
        end
    end

endmodule

// File: rtl/led_matrix_spiral_animator_core.sv
// ----------------------------------------------------------------------------
// led_matrix_spiral_animator_core
// Column scan driver for a multiplexed square LED matrix with a spiral
// pixel-inversion animation and a plain register write port.
// ----------------------------------------------------------------------------
// An accepted input beat shows up as an output beat in the next cycle.
// Throughput: one beat per cycle while the output is not stalled; the output
// register is refilled in the same cycle that its beat is taken.
// Reset: asynchronous, active low; frame all ones, scan, walker and dwell
// counters at zero, registers at their reset values, output empty.
module led_matrix_spiral_animator_core
    import lmsa_pkg::*;
#(
    parameter int MATRIX_SIDE = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration port.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input channel.
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  slot_tick,
    // Output channel.
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OUT_W-1:0]      column_select,
    output logic [OUT_W-1:0]      row_levels,
    output logic [RING_OUT_W-1:0] ring_index
);

    localparam int RC_W   = $clog2(MATRIX_SIDE);
    localparam int RINGS  = MATRIX_SIDE / 2;
    localparam int RING_W = (RINGS > 1) ? $clog2(RINGS) : 1;

    logic [DWELL_BASE_W-1:0] dwell_base_reg;
    logic [DWELL_STEP_W-1:0] dwell_step_reg;
    logic [RC_W-1:0]         scan_col_reg;
    logic                    out_valid_reg;
    logic [OUT_W-1:0]        column_select_reg;
    logic [OUT_W-1:0]        row_levels_reg;
    logic [RING_OUT_W-1:0]   ring_index_reg;

    logic                    accept;
    logic                    tick_en;
    logic                    toggle_en;
    logic [RC_W-1:0]         toggle_row;
    logic [RC_W-1:0]         toggle_col;
    logic [RING_W-1:0]       ring;
    logic [MATRIX_SIDE-1:0]  col_rows;
    logic [OUT_W-1:0]        column_select_next;
    logic [OUT_W-1:0]        row_levels_next;

    // Handshake: take a beat whenever the output register is free or drains.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign tick_en  = accept && slot_tick;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_base_reg <= DWELL_BASE_RESET;
            dwell_step_reg <= DWELL_STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DWELL_BASE: dwell_base_reg <= cfg_data[DWELL_BASE_W-1:0];
                CFG_DWELL_STEP: dwell_step_reg <= cfg_data[DWELL_STEP_W-1:0];
                default:        ;
            endcase
        end
    end

    lmsa_walker #(
        .MATRIX_SIDE (MATRIX_SIDE)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_en    (tick_en),
        .dwell_base (dwell_base_reg),
        .dwell_step (dwell_step_reg),
        .toggle_en  (toggle_en),
        .toggle_row (toggle_row),
        .toggle_col (toggle_col),
        .ring       (ring)
    );

    lmsa_frame #(
        .MATRIX_SIDE (MATRIX_SIDE)
    ) u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .toggle_en  (toggle_en),
        .toggle_row (toggle_row),
        .toggle_col (toggle_col),
        .scan_col   (scan_col_reg),
        .col_rows   (col_rows)
    );

    // Map the scanned column onto the 8-bit output fields.
    always_comb
    begin
        column_select_next = '0;
        row_levels_next    = '0;
        for (int i = 0; i < OUT_W; i++)
        begin
            if (i < MATRIX_SIDE)
            begin
                column_select_next[i] = (scan_col_reg == RC_W'(i));
                row_levels_next[i]    = col_rows[i];
            end
        end
    end

    // Scan column counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_col_reg <= '0;
        end
        else if (tick_en)
        begin
            scan_col_reg <= (scan_col_reg == RC_W'(MATRIX_SIDE - 1)) ?
                            '0 : scan_col_reg + RC_W'(1);
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            column_select_reg <= column_select_next;
            row_levels_reg    <= row_levels_next;
            ring_index_reg    <= RING_OUT_W'(ring);
        end
    end

    assign out_valid     = out_valid_reg;
    assign column_select = column_select_reg;
    assign row_levels    = row_levels_reg;
    assign ring_index    = ring_index_reg;

endmodule

// File: rtl/lmsa_checker.sv
// ----------------------------------------------------------------------------
// lmsa_checker
// Port-level checks for the spiral animator core, bound to the top level.
// ----------------------------------------------------------------------------
module lmsa_checker
    import lmsa_pkg::*;
#(
    parameter int MATRIX_SIDE = 8
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [OUT_W-1:0]      column_select,
    input logic [OUT_W-1:0]      row_levels,
    input logic [RING_OUT_W-1:0] ring_index
);

    // A stalled output beat holds its payload.
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(column_select) && $stable(row_levels)
            && $stable(ring_index);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("output beat changed while stalled");

    // Every accepted input beat shows up as an output beat the next cycle.
    property p_accept_to_out;
        @(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid;
    endproperty
    a_accept_to_out: assert property (p_accept_to_out)
        else $error("accepted beat did not reach the output");

    // Exactly one column is selected while the matrix fits the output field.
    property p_col_onehot;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (MATRIX_SIDE > OUT_W) || $onehot(column_select);
    endproperty
    a_col_onehot: assert property (p_col_onehot)
        else $error("column select is not one-hot");

    // The output is empty on the first cycle after reset.
    property p_reset_empty;
        @(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid;
    endproperty
    a_reset_empty: assert property (p_reset_empty)
        else $error("output valid right after reset");

endmodule

bind led_matrix_spiral_animator_core lmsa_checker #(
    .MATRIX_SIDE (MATRIX_SIDE)
) u_lmsa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .column_select (column_select),
    .row_levels    (row_levels),
    .ring_index    (ring_index)
);
